// ===== design/wsclk_pkg.sv =====
// wsclk_pkg: shared widths, command codes and types for the wsclock page replacer
// no dependencies; used by every module in the design folder
package wsclk_pkg;

	localparam int unsigned FRAMES_DEF = 16;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned THR_W      = 20;
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned FRAME_W    = 4;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(49);

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 2'd0,
		CMD_REF     = 2'd1,
		CMD_INSTALL = 2'd2,
		CMD_SELECT  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0] age;
		logic              gt;
	} age_res_t;

endpackage

// ===== design/working_set_clock_replacer_unit.sv =====
// Working-set clock page replacer over FRAMES frames. Tick, reference and install
// requests finish in the cycle they are accepted. A select request scans the frames
// from the hand at one frame per cycle through the last-use memory read port and the
// shared age unit: a threshold pass that stops at the first unreferenced frame idle
// past the threshold, then, if no frame qualified, an oldest-frame pass over all
// frames, then a step to post the response. A select holds req_ready low until the
// response is posted, which also waits while the previous response sits unaccepted
// in the response register.
// depends on wsclk_pkg, wsclk_stamp_mem and wsclk_age_unit
module working_set_clock_replacer_unit #(
	parameter int unsigned FRAMES = wsclk_pkg::FRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [wsclk_pkg::CMD_W-1:0]   command,
	input  logic [wsclk_pkg::FRAME_W-1:0] frame,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [wsclk_pkg::FRAME_W-1:0] victim_frame,
	output logic                          chosen_by_threshold,
	input  logic                          cfg_wr_en,
	input  logic [wsclk_pkg::THR_W-1:0]   cfg_wr_data
);
	import wsclk_pkg::*;

	localparam int unsigned FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int unsigned CW = $clog2(FRAMES + 1);
	localparam int unsigned XW = 8;
	localparam logic [CW-1:0] FRAMES_CNT = CW'(FRAMES);
	localparam logic [CW-1:0] LAST_CNT   = CW'(FRAMES - 1);
	localparam logic [FW-1:0] LAST_POS   = FW'(FRAMES - 1);
	localparam logic [XW-1:0] FRAMES_X   = XW'(FRAMES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_THR,
		ST_OLD,
		ST_DONE
	} state_t;

	function automatic logic [FW-1:0] next_pos(input logic [FW-1:0] p);
		return (p == LAST_POS) ? '0 : FW'(p + 1'b1);
	endfunction

	state_t            state_q;
	logic [FRAMES-1:0] ref_q;
	logic [TIME_W-1:0] now_q;
	logic [THR_W-1:0]  thr_q;
	logic [FW-1:0]     hand_q;
	logic [FW-1:0]     start_q;
	logic [FW-1:0]     rd_pos_q;
	logic [CW-1:0]     issue_cnt_q;
	logic              ev_valid_s1;
	logic [FW-1:0]     ev_pos_s1;
	logic              ev_first_s1;
	logic              ev_last_s1;
	logic [FW-1:0]     best_pos_q;
	logic [TIME_W-1:0] best_age_q;
	logic [FW-1:0]     victim_q;
	logic              by_thr_q;
	logic              rsp_valid_q;
	logic [FRAME_W-1:0] rsp_victim_q;
	logic              rsp_thr_q;

	logic              req_fire;
	cmd_t              cmd;
	logic [XW-1:0]     frame_ext;
	logic              frame_ok;
	logic [FW-1:0]     frame_idx;
	logic [FW-1:0]     start_pos;
	logic              issuing;
	logic              ev_ref;
	logic              stamp_now;
	logic              thr_hit;
	logic              old_take;
	logic              mem_wr_en;
	logic [FW-1:0]     mem_wr_addr;
	logic [TIME_W-1:0] mem_rd_data;
	logic [TIME_W-1:0] bound;
	age_res_t          age_res;
	logic [XW-1:0]     victim_ext;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign cmd       = cmd_t'(command);
	assign frame_ext = XW'(frame);
	assign frame_ok  = frame_ext < FRAMES_X;
	assign frame_idx = frame_ext[FW-1:0];
	assign start_pos = (XW'(hand_q) >= FRAMES_X) ? '0 : hand_q;
	assign victim_ext = XW'(victim_q);

	assign issuing = ((state_q == ST_THR) || (state_q == ST_OLD)) && (issue_cnt_q != FRAMES_CNT);
	assign ev_ref  = ref_q[ev_pos_s1];
	assign bound   = (state_q == ST_THR) ? TIME_W'(thr_q) : best_age_q;

	assign stamp_now = (state_q == ST_THR) && ev_valid_s1 && ev_ref;
	assign thr_hit   = (state_q == ST_THR) && ev_valid_s1 && !ev_ref && age_res.gt;
	assign old_take  = (state_q == ST_OLD) && ev_valid_s1 && (ev_first_s1 || age_res.gt);

	assign mem_wr_en   = (req_fire && (cmd == CMD_INSTALL) && frame_ok) || stamp_now;
	assign mem_wr_addr = stamp_now ? ev_pos_s1 : frame_idx;

	wsclk_stamp_mem #(
		.FRAMES (FRAMES),
		.FW     (FW)
	) u_stamp_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (now_q),
		.rd_addr (rd_pos_q),
		.rd_data (mem_rd_data)
	);

	wsclk_age_unit u_age_unit (
		.now_time (now_q),
		.stamp    (mem_rd_data),
		.bound    (bound),
		.res      (age_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ref_q        <= '0;
			now_q        <= '0;
			thr_q        <= THR_RESET;
			hand_q       <= '0;
			start_q      <= '0;
			rd_pos_q     <= '0;
			issue_cnt_q  <= '0;
			ev_valid_s1  <= 1'b0;
			ev_pos_s1    <= '0;
			ev_first_s1  <= 1'b0;
			ev_last_s1   <= 1'b0;
			best_pos_q   <= '0;
			best_age_q   <= '0;
			victim_q     <= '0;
			by_thr_q     <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_victim_q <= '0;
			rsp_thr_q    <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						unique case (cmd)
							CMD_TICK: begin
								now_q <= now_q + 1'b1;
							end
							CMD_REF, CMD_INSTALL: begin
								if (frame_ok) begin
									ref_q[frame_idx] <= 1'b1;
								end
							end
							CMD_SELECT: begin
								start_q     <= start_pos;
								rd_pos_q    <= start_pos;
								issue_cnt_q <= '0;
								ev_valid_s1 <= 1'b0;
								state_q     <= ST_THR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_THR: begin
					ev_valid_s1 <= issuing;
					ev_pos_s1   <= rd_pos_q;
					ev_first_s1 <= (issue_cnt_q == '0);
					ev_last_s1  <= (issue_cnt_q == LAST_CNT);
					if (issuing) begin
						rd_pos_q    <= next_pos(rd_pos_q);
						issue_cnt_q <= issue_cnt_q + 1'b1;
					end
					if (stamp_now) begin
						ref_q[ev_pos_s1] <= 1'b0;
					end
					if (thr_hit) begin
						victim_q    <= ev_pos_s1;
						by_thr_q    <= 1'b1;
						ev_valid_s1 <= 1'b0;
						state_q     <= ST_DONE;
					end else if (ev_valid_s1 && ev_last_s1) begin
						rd_pos_q    <= start_q;
						issue_cnt_q <= '0;
						ev_valid_s1 <= 1'b0;
						state_q     <= ST_OLD;
					end
				end
				ST_OLD: begin
					ev_valid_s1 <= issuing;
					ev_pos_s1   <= rd_pos_q;
					ev_first_s1 <= (issue_cnt_q == '0);
					ev_last_s1  <= (issue_cnt_q == LAST_CNT);
					if (issuing) begin
						rd_pos_q    <= next_pos(rd_pos_q);
						issue_cnt_q <= issue_cnt_q + 1'b1;
					end
					if (old_take) begin
						best_pos_q <= ev_pos_s1;
						best_age_q <= age_res.age;
					end
					if (ev_valid_s1 && ev_last_s1) begin
						victim_q    <= old_take ? ev_pos_s1 : best_pos_q;
						by_thr_q    <= 1'b0;
						ev_valid_s1 <= 1'b0;
						state_q     <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_victim_q <= victim_ext[FRAME_W-1:0];
						rsp_thr_q    <= by_thr_q;
						hand_q       <= next_pos(victim_q);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid           = rsp_valid_q;
	assign victim_frame        = rsp_victim_q;
	assign chosen_by_threshold = rsp_thr_q;

endmodule

// ===== design/wsclk_stamp_mem.sv =====
// wsclk_stamp_mem: last-use time memory, one write and one registered read port
// entries never stamped read as zero through a per-frame stamped bit
// depends on wsclk_pkg
module wsclk_stamp_mem #(
	parameter int unsigned FRAMES = wsclk_pkg::FRAMES_DEF,
	parameter int unsigned FW     = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [FW-1:0]                 wr_addr,
	input  logic [wsclk_pkg::TIME_W-1:0]  wr_data,
	input  logic [FW-1:0]                 rd_addr,
	output logic [wsclk_pkg::TIME_W-1:0]  rd_data
);
	import wsclk_pkg::*;

	logic [TIME_W-1:0] mem_q [FRAMES];
	logic [FRAMES-1:0] stamped_q;
	logic [TIME_W-1:0] rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamped_q <= '0;
		end else if (wr_en) begin
			stamped_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= stamped_q[rd_addr] ? mem_q[rd_addr] : '0;
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/wsclk_age_unit.sv =====
// wsclk_age_unit: shared idle-age unit, wrapping subtract and unsigned compare
// used for both the threshold pass and the oldest-frame pass; depends on wsclk_pkg
module wsclk_age_unit (
	input  logic [wsclk_pkg::TIME_W-1:0] now_time,
	input  logic [wsclk_pkg::TIME_W-1:0] stamp,
	input  logic [wsclk_pkg::TIME_W-1:0] bound,
	output wsclk_pkg::age_res_t          res
);
	import wsclk_pkg::*;

	logic [TIME_W-1:0] age;

	assign age    = now_time - stamp;
	assign res.age = age;
	assign res.gt  = age > bound;

endmodule
